// ----- design/pqe_pkg.sv -----
// Shared types and constants for the P-square quantile estimator.
// Depends on nothing; imported by p_square_quantile_estimator.
`default_nettype none
package pqe_pkg;

	// Default sample and fraction widths.
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF    = 16;

	// Fixed field widths.
	localparam int Q_BITS = 16;
	localparam int CNT_W  = 32;
	localparam int POS_W  = 32;

	// Reset value of the quantile register (one half).
	localparam logic [Q_BITS-1:0] Q_RESET = Q_BITS'(1) << (Q_BITS - 1);

	// Number of markers.
	localparam int NMARK = 5;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PICK,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_CHECK,
		ST_DONE
	} state_t;

	// Which quotient of a marker adjustment the shared unit is working on.
	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_S,
		PH_LIN
	} phase_t;

endpackage
`default_nettype wire

// ----- design/p_square_quantile_estimator.sv -----
// Top level of the five-marker P-square quantile estimator.
// Depends on pqe_pkg for types and constants.
//
// Streaming P-square estimator: each input transaction carries one signed sample and a
// restart flag, and produces exactly one output transaction with the estimate (signed fixed
// point, FRAC_BITS fraction bits), a warm flag and the saturating sample count. The user
// must write the quantile register through cfg_write/cfg_data only while the block is
// idle; the block itself does not enforce this. The block handles one sample at a time
// and holds in_stall high while it works. A warm-up sample goes from the load state
// straight to the done state. After warm-up, each middle marker that has to move runs
// through one shared shift-add multiplier and one shared restoring divider, one bit per
// cycle: two multiplies and three or four divisions, the fourth for the linear fallback.
// The finished result sits in an output register, so the next sample is taken while it
// waits.
`default_nettype none
module p_square_quantile_estimator #(
	parameter int SAMPLE_WIDTH = pqe_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = pqe_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [pqe_pkg::Q_BITS-1:0]             cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]         observation,
	input  wire logic                                   restart,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [SAMPLE_WIDTH+FRAC_BITS-1:0]    estimate,
	output logic                                        warmed_up,
	output logic [pqe_pkg::CNT_W-1:0]                   samples_seen
);
	import pqe_pkg::*;

	localparam int HW    = SAMPLE_WIDTH + FRAC_BITS;
	localparam int ML_W  = POS_W + 1;
	localparam int NUM_W = HW + ML_W + 1;
	localparam int RW    = ML_W + 1;
	localparam int ITW   = $clog2(NUM_W + 1);
	localparam int DP_W  = POS_W + Q_BITS + 3;
	localparam int IX_W  = Q_BITS + 4;
	localparam logic signed [DP_W-1:0] ONE = DP_W'(1) <<< (Q_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	state_t st_q, st_nxt;
	phase_t ph_q;

	logic [Q_BITS-1:0]          q_q;
	logic signed [HW-1:0]       h_q [NMARK];
	logic [POS_W-1:0]           n_q [NMARK];
	logic [CNT_W-1:0]           cnt_q;
	logic [1:0]                 step_q;
	logic [2:0]                 mi_q;
	logic                       up_q;
	logic                       ovalid_q;

	logic signed [HW-1:0]       x_q;
	logic                       rst_q;
	logic [CNT_W-1:0]           c_q;
	logic [CNT_W+Q_BITS-1:0]    dq_q;
	logic [POS_W-1:0]           gl_q, gu_q;
	logic [HW-1:0]              hl_q, hu_q;
	logic [ML_W-1:0]            mu_q;
	logic [NUM_W-1:0]           acc_q, a_q;
	logic [HW-1:0]              mc_q;
	logic [ML_W-1:0]            mlr_q;
	logic [RW-1:0]              rem_q;
	logic [ML_W-1:0]            dvs_q;
	logic [ITW-1:0]             it_q;
	logic signed [HW-1:0]       est_q;
	logic                       warm_q;
	logic [CNT_W-1:0]           seen_q;

	// Effective count and positions after an optional restart.
	logic [CNT_W-1:0] cnt_e;
	logic [POS_W-1:0] pos_e [NMARK];
	logic             warm_path, adj_path;

	always_comb begin
		cnt_e = rst_q ? '0 : cnt_q;
		for (int j = 0; j < NMARK; j++) begin
			pos_e[j] = rst_q ? POS_W'(j) : n_q[j];
		end
		warm_path = cnt_e < CNT_W'(NMARK);
		adj_path  = !warm_path && (cnt_e != CNT_MAX);
	end

	// Sorted insertion during warm-up; a sample goes after equal entries.
	logic               le [NMARK];
	logic [2:0]         ins_p;
	logic signed [HW-1:0] ins_h [NMARK];

	always_comb begin
		ins_p = '0;
		for (int j = 0; j < NMARK; j++) begin
			le[j] = (CNT_W'(j) < cnt_e) && (h_q[j] <= x_q);
			ins_p = ins_p + 3'(le[j]);
		end
		for (int j = 0; j < NMARK; j++) begin
			if (3'(j) < ins_p) begin
				ins_h[j] = h_q[j];
			end else if (3'(j) == ins_p) begin
				ins_h[j] = x_q;
			end else if (CNT_W'(j) <= cnt_e) begin
				ins_h[j] = h_q[j-1];
			end else begin
				ins_h[j] = h_q[j];
			end
		end
	end

	// Marker selection and the move decision for the current step.
	logic [2:0]             mi_c;
	logic [POS_W-1:0]       cur_c, glc, guc;
	logic signed [DP_W-1:0] des_c, dp_c;
	logic                   up_c, dn_c;
	logic [CNT_W+Q_BITS:0]  d2_c, d3_c;

	always_comb begin
		mi_c = q_q[Q_BITS-1] ? (3'(step_q) + 3'd1) : (3'd3 - 3'(step_q));
		if (mi_c < 3'd1 || mi_c > 3'd3) begin
			mi_c = 3'd2;
		end
		cur_c = n_q[mi_c];
		glc   = cur_c - n_q[mi_c - 3'd1];
		guc   = n_q[mi_c + 3'd1] - cur_c;
		d2_c  = {dq_q, 1'b0};
		d3_c  = (CNT_W + Q_BITS + 1)'({c_q, {Q_BITS{1'b0}}}) + (CNT_W + Q_BITS + 1)'(dq_q);
		case (mi_c)
			3'd1:    des_c = DP_W'(dq_q);
			3'd2:    des_c = DP_W'(d2_c);
			default: des_c = DP_W'(d3_c);
		endcase
		dp_c = des_c - (DP_W'(cur_c) <<< (Q_BITS + 1));
		up_c = (dp_c >= ONE) && (guc > POS_W'(1));
		dn_c = (dp_c <= -ONE) && (glc > POS_W'(1));
	end

	// Shared unit: one shift-add multiply step and one restoring divide step.
	logic [NUM_W-1:0] mul_n;
	logic [RW:0]      div_t;
	logic             div_ge;
	logic [RW-1:0]    rem_n;
	logic [NUM_W-1:0] quo_n;
	logic             last_it;

	always_comb begin
		mul_n   = (acc_q << 1) + (mlr_q[ML_W-1] ? NUM_W'(mc_q) : '0);
		div_t   = {rem_q, acc_q[NUM_W-1]};
		div_ge  = div_t >= (RW + 1)'(dvs_q);
		rem_n   = div_ge ? RW'(div_t - (RW + 1)'(dvs_q)) : RW'(div_t);
		quo_n   = {acc_q[NUM_W-2:0], div_ge};
		last_it = it_q == ITW'(1);
	end

	// Acceptance test of the parabolic step.
	logic ok_c;

	always_comb begin
		if (up_q) begin
			ok_c = (acc_q < NUM_W'(hu_q)) && (acc_q != '0 || hl_q != '0);
		end else begin
			ok_c = (acc_q < NUM_W'(hl_q)) && (acc_q != '0 || hu_q != '0);
		end
	end

	// Result fields taken from the updated state.
	logic [2:0]      cm1;
	logic [IX_W-1:0] ixw;
	logic [3:0]      ix;
	logic [2:0]      eix;

	always_comb begin
		cm1 = cnt_q[2:0] - 3'd1;
		ixw = IX_W'(cm1) * IX_W'(q_q) + (IX_W'(1) << (Q_BITS - 1));
		ix  = ixw[Q_BITS+3:Q_BITS];
		if (cnt_q == '0) begin
			eix = 3'd0;
		end else if (cnt_q > CNT_W'(NMARK)) begin
			eix = 3'd2;
		end else if (ix > 4'd4) begin
			eix = 3'd4;
		end else begin
			eix = ix[2:0];
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) st_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				st_nxt = adj_path ? ST_PICK : ST_DONE;
			end
			ST_PICK: begin
				if (step_q == 2'd3) begin
					st_nxt = ST_DONE;
				end else if (up_c || dn_c) begin
					st_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				if (last_it) st_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (last_it) begin
					case (ph_q)
						PH_A:    st_nxt = ST_MUL;
						PH_B:    st_nxt = ST_SUM;
						PH_S:    st_nxt = ST_CHECK;
						default: st_nxt = ST_PICK;
					endcase
				end
			end
			ST_SUM: begin
				st_nxt = ST_DIV;
			end
			ST_CHECK: begin
				st_nxt = ok_c ? ST_PICK : ST_DIV;
			end
			ST_DONE: begin
				if (!ovalid_q || !out_stall) st_nxt = ST_IDLE;
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	logic load_out;

	always_comb begin
		in_stall = st_q != ST_IDLE;
		load_out = (st_q == ST_DONE) && (!ovalid_q || !out_stall);
	end

	// Control and estimator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ph_q     <= PH_A;
			q_q      <= Q_RESET;
			cnt_q    <= '0;
			step_q   <= '0;
			mi_q     <= 3'd2;
			up_q     <= 1'b0;
			ovalid_q <= 1'b0;
			for (int j = 0; j < NMARK; j++) begin
				h_q[j] <= '0;
				n_q[j] <= POS_W'(j);
			end
		end else begin
			st_q <= st_nxt;
			if (cfg_write) q_q <= cfg_data;

			// Output register handshake.
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end

			case (st_q)
				ST_LOAD: begin
					step_q <= '0;
					if (warm_path) begin
						for (int j = 0; j < NMARK; j++) begin
							h_q[j] <= ins_h[j];
							n_q[j] <= pos_e[j];
						end
						cnt_q <= cnt_e + CNT_W'(1);
					end else if (adj_path) begin
						if (x_q < h_q[0]) h_q[0] <= x_q;
						if (x_q >= h_q[4]) h_q[4] <= x_q;
						n_q[0] <= pos_e[0];
						for (int j = 1; j < NMARK; j++) begin
							n_q[j] <= (j == NMARK - 1 || x_q < h_q[j]) ?
								pos_e[j] + POS_W'(1) : pos_e[j];
						end
						cnt_q <= cnt_e + CNT_W'(1);
					end
				end
				ST_PICK: begin
					if (step_q != 2'd3) begin
						mi_q <= mi_c;
						up_q <= up_c;
						ph_q <= PH_A;
						if (!(up_c || dn_c)) step_q <= step_q + 2'd1;
					end
				end
				ST_DIV: begin
					if (last_it && ph_q == PH_A) ph_q <= PH_B;
					if (last_it && ph_q == PH_LIN) begin
						h_q[mi_q] <= up_q ? h_q[mi_q] + $signed(quo_n[HW-1:0])
							: h_q[mi_q] - $signed(quo_n[HW-1:0]);
						n_q[mi_q] <= up_q ? n_q[mi_q] + POS_W'(1) : n_q[mi_q] - POS_W'(1);
						step_q    <= step_q + 2'd1;
					end
				end
				ST_SUM: begin
					ph_q <= PH_S;
				end
				ST_CHECK: begin
					if (ok_c) begin
						h_q[mi_q] <= up_q ? h_q[mi_q] + $signed(acc_q[HW-1:0])
							: h_q[mi_q] - $signed(acc_q[HW-1:0]);
						n_q[mi_q] <= up_q ? n_q[mi_q] + POS_W'(1) : n_q[mi_q] - POS_W'(1);
						step_q    <= step_q + 2'd1;
					end else begin
						ph_q <= PH_LIN;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers of the shared unit and the result register.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q   <= {observation, {FRAC_BITS{1'b0}}};
				rst_q <= restart;
			end
			ST_LOAD: begin
				c_q  <= cnt_e;
				dq_q <= (CNT_W + Q_BITS)'(cnt_e) * (CNT_W + Q_BITS)'(q_q);
			end
			ST_PICK: begin
				// Set up the first product: (gl +/- 1) * (hu).
				gl_q  <= glc;
				gu_q  <= guc;
				hl_q  <= HW'(h_q[mi_c] - h_q[mi_c - 3'd1]);
				hu_q  <= HW'(h_q[mi_c + 3'd1] - h_q[mi_c]);
				mc_q  <= HW'(h_q[mi_c + 3'd1] - h_q[mi_c]);
				mlr_q <= up_c ? ML_W'(glc) + ML_W'(1) : ML_W'(glc) - ML_W'(1);
				mu_q  <= up_c ? ML_W'(guc) - ML_W'(1) : ML_W'(guc) + ML_W'(1);
				dvs_q <= ML_W'(guc);
				acc_q <= '0;
				it_q  <= ITW'(ML_W);
			end
			ST_MUL: begin
				acc_q <= mul_n;
				mlr_q <= mlr_q << 1;
				if (last_it) begin
					rem_q <= '0;
					it_q  <= ITW'(NUM_W);
				end else begin
					it_q <= it_q - ITW'(1);
				end
			end
			ST_DIV: begin
				acc_q <= quo_n;
				rem_q <= rem_n;
				if (last_it) begin
					if (ph_q == PH_A) begin
						// Set up the second product: (gu -/+ 1) * (hl).
						a_q   <= quo_n;
						acc_q <= '0;
						mc_q  <= hl_q;
						mlr_q <= mu_q;
						dvs_q <= ML_W'(gl_q);
						it_q  <= ITW'(ML_W);
					end
				end else begin
					it_q <= it_q - ITW'(1);
				end
			end
			ST_SUM: begin
				acc_q <= a_q + acc_q;
				dvs_q <= ML_W'(gl_q) + ML_W'(gu_q);
				rem_q <= '0;
				it_q  <= ITW'(NUM_W);
			end
			ST_CHECK: begin
				// Linear fallback: neighbor height gap over position gap.
				acc_q <= up_q ? NUM_W'(hu_q) : NUM_W'(hl_q);
				dvs_q <= up_q ? ML_W'(gu_q) : ML_W'(gl_q);
				rem_q <= '0;
				it_q  <= ITW'(NUM_W);
			end
			default: begin
			end
		endcase

		if (load_out) begin
			est_q  <= h_q[eix];
			warm_q <= cnt_q >= CNT_W'(NMARK);
			seen_q <= cnt_q;
		end
	end

	assign out_valid    = ovalid_q;
	assign estimate     = est_q;
	assign warmed_up    = warm_q;
	assign samples_seen = seen_q;

endmodule
`default_nettype wire

// ----- tb/sv/pqe_checker.sv -----
// Scoreboard for the P-square quantile estimator: watches both channels and the
// quantile register port, predicts each result and compares it. Depends on pqe_pkg.
`timescale 1ns / 1ps
module pqe_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [pqe_pkg::Q_BITS-1:0] cfg_data,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic signed [31:0]         observation,
	input  wire logic                       restart,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic signed [47:0]         estimate,
	input  wire logic                       warmed_up,
	input  wire logic [31:0]                samples_seen,
	output int                              errors,
	output int                              pending,
	output int                              checked
);
	localparam logic [63:0] OFFSET = 64'h8000_0000_0000_0000;
	localparam longint UNIT = 64'sd131072;

	typedef struct packed {
		logic signed [47:0] est;
		logic               warm;
		logic [31:0]        seen;
	} quant_result_t;

	quant_result_t expected_results[$];

	// Private copy of the estimator state; heights are offset binary.
	logic [63:0] height [5];
	logic [63:0] place [5];
	logic [63:0] taken;
	logic [15:0] qfrac;

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// One parabolic or linear step of a middle marker toward its desired position.
	function automatic void move_marker(int i, longint desired);
		longint cur, dp;
		logic [63:0] gl, gu, ml, mu, hl, hu;
		logic [127:0] s;
		bit up, dn, ok;
		cur = longint'(place[i]);
		gl = place[i] - place[i-1];
		gu = place[i+1] - place[i];
		dp = desired - cur * UNIT;
		up = dp >= UNIT && gu > 1;
		dn = dp <= -UNIT && gl > 1;
		if (!up && !dn)
			return;
		hl = height[i] - height[i-1];
		hu = height[i+1] - height[i];
		ml = up ? gl + 1 : gl - 1;
		mu = up ? gu - 1 : gu + 1;
		s = (128'(ml) * 128'(hu)) / 128'(gu) + (128'(mu) * 128'(hl)) / 128'(gl);
		s = s / 128'(gl + gu);
		if (up)
			ok = s[127:64] == 0 && s[63:0] < hu && (s[63:0] > 0 || hl > 0);
		else
			ok = s[127:64] == 0 && s[63:0] < hl && (s[63:0] > 0 || hu > 0);
		if (ok)
			height[i] = up ? height[i] + s[63:0] : height[i] - s[63:0];
		else
			height[i] = up ? height[i] + hu / gu : height[i] - hl / gl;
		place[i] = up ? place[i] + 1 : place[i] - 1;
	endfunction

	// Advance the estimator by one sample and return the result it reports.
	function automatic quant_result_t take_sample(logic signed [31:0] obs, logic rst);
		logic signed [63:0] wide;
		logic [63:0] x, c, idx, est;
		longint d1, d2, d3;
		int j, k;
		quant_result_t r;
		wide = obs;
		x = (wide << 16) ^ OFFSET;
		if (rst) begin
			taken = 0;
			for (int m = 0; m < 5; m++) place[m] = m;
		end
		c = taken;
		if (c < 5) begin
			// Warm-up: insertion into the sorted buffer, after equal entries.
			j = int'(c);
			while (j > 0 && height[j-1] > x) begin
				height[j] = height[j-1];
				j--;
			end
			height[j] = x;
			taken = c + 1;
		end else if (c < 64'hFFFF_FFFF) begin
			d1 = longint'(c * qfrac);
			d2 = longint'(2 * c * qfrac);
			d3 = longint'(c * (64'd65536 + qfrac));
			if (x < height[0]) begin height[0] = x; k = 0; end
			else if (x < height[1]) k = 0;
			else if (x < height[2]) k = 1;
			else if (x < height[3]) k = 2;
			else if (x < height[4]) k = 3;
			else begin height[4] = x; k = 3; end
			for (int m = k + 1; m < 5; m++) place[m]++;
			if (qfrac >= 16'h8000) begin
				move_marker(1, d1);
				move_marker(2, d2);
				move_marker(3, d3);
			end else begin
				move_marker(3, d3);
				move_marker(2, d2);
				move_marker(1, d1);
			end
			taken = c + 1;
		end
		c = taken;
		if (c <= 5) begin
			idx = c == 0 ? 0 : (((c - 1) * qfrac + 64'd32768) >> 16);
			if (idx > 4) idx = 4;
			est = height[idx];
		end else begin
			est = height[2];
		end
		est = est ^ OFFSET;
		r.est = est[47:0];
		r.warm = c >= 5;
		r.seen = c[31:0];
		return r;
	endfunction

	// Results are checked before new samples are predicted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		quant_result_t want;
		if (!arst_n) begin
			for (int m = 0; m < 5; m++) begin
				height[m] = OFFSET;
				place[m] = m;
			end
			taken = 0;
			qfrac = pqe_pkg::Q_RESET;
			expected_results.delete();
			errors = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_write)
				qfrac = cfg_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("unexpected transaction", 64'(estimate), 0);
				end else begin
					want = expected_results.pop_front();
					if (estimate !== want.est)
						report("estimate", 64'(estimate), 64'(want.est));
					if (warmed_up !== want.warm)
						report("warmed_up", 64'(warmed_up), 64'(want.warm));
					if (samples_seen !== want.seen)
						report("samples_seen", 64'(samples_seen), 64'(want.seen));
					checked++;
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(take_sample(observation, restart));
			pending = expected_results.size();
		end
	end
endmodule

// ----- tb/sv/p_square_quantile_estimator_tb.sv -----
// Top of the quantile estimator testbench: clock, reset, stimulus and verdict.
// Depends on pqe_pkg, the estimator RTL and the pqe_checker scoreboard.
`timescale 1ns / 1ps
module p_square_quantile_estimator_tb;
	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [pqe_pkg::Q_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] observation;
	logic restart;
	logic out_valid;
	logic out_stall;
	logic signed [47:0] estimate;
	logic warmed_up;
	logic [31:0] samples_seen;

	int errors, pending, checked;
	int send_idle_pct, recv_idle_pct;
	int samples_sent, restarts_sent;
	bit hold_req, hold_done;

	p_square_quantile_estimator uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.observation(observation), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.estimate(estimate), .warmed_up(warmed_up), .samples_seen(samples_seen)
	);

	pqe_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.observation(observation), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.estimate(estimate), .warmed_up(warmed_up), .samples_seen(samples_seen),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// Free-running clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog against a hung handshake.
	initial begin
		#200_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off to back the block up.
	initial begin
		int held;
		out_stall = 1;
		held = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1;
				held++;
				if (held == 4000) hold_done = 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offer one sample, wait until it is accepted, then withdraw valid.
	task automatic send_sample(logic signed [31:0] obs, logic rst);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			repeat ($urandom_range(4)) @(negedge clk);
		end
		in_valid <= 1;
		observation <= obs;
		restart <= rst;
		samples_sent++;
		if (rst) restarts_sent++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 0;
	endtask

	// Drain the block, then write the quantile register while it is idle.
	task automatic set_quantile(logic [15:0] q);
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (1500) @(negedge clk);
		cfg_write <= 1;
		cfg_data <= q;
		@(negedge clk);
		cfg_write <= 0;
	endtask

	// Mix of full-range values, clustered values with ties, and extremes.
	function automatic logic signed [31:0] pick_observation();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(40)) - 20;
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return 32'sd1000 * $signed($urandom_range(9)) + $urandom_range(999);
		endcase
	endfunction

	initial begin
		logic [15:0] q_plan [8];
		in_valid = 0;
		observation = 0;
		restart = 0;
		cfg_write = 0;
		cfg_data = 0;
		send_idle_pct = 29;
		recv_idle_pct = 54;
		hold_req = 0;
		hold_done = 0;
		samples_sent = 0;
		restarts_sent = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: warm-up with extremes and ties, restarts early and mid-stream.
		send_sample(32'sh7FFF_FFFF, 1);
		send_sample(32'sh8000_0000, 0);
		send_sample(0, 0);
		send_sample(0, 0);
		send_sample(-1, 0);
		send_sample(-1, 0);
		send_sample(32'sh8000_0000, 0);
		send_sample(32'sh7FFF_FFFF, 0);
		send_sample(1, 0);
		send_sample(5, 0);
		send_sample(-7, 0);
		send_sample(3, 1);
		send_sample(3, 0);
		send_sample(2, 0);
		send_sample(3, 1);
		send_sample(9, 0);
		for (int i = 0; i < 9; i++) send_sample(i * 100 - 300, 0);

		q_plan = '{16'd1, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd13107, 16'd52429,
			16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1))};
		for (int ph = 0; ph < 8; ph++) begin
			set_quantile(q_plan[ph]);
			if (ph == 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 29;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 1) hold_req = 1;
			// Mostly long runs after a restart so the markers get to move.
			for (int n = 0; n < 240; n++)
				send_sample(pick_observation(), n == 0 || $urandom_range(149) == 0);
		end

		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (1500) @(negedge clk);
		$display("Sent %0d samples (%0d with restart) over 9 quantile settings;", samples_sent,
			restarts_sent);
		$display("%0d results compared, %0d mismatches.", checked, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
